// File: design/ostb_pkg.sv
// ostb_pkg: shared types and codes for the one-shot soft timer bank.
// Used by ostb_ctrl, ostb_dpath and one_shot_soft_timer_bank.
// No dependencies.
package ostb_pkg;

   // Request opcodes
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_CREATE  = 3'd1,
      OP_CONTROL = 3'd2,
      OP_DELETE  = 3'd3,
      OP_RESET   = 3'd4
   } op_type;

   // Result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   // Timer count saturates here
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // Timers addressable by a 3-bit id
   localparam int MAX_SLOTS = 8;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture request fields
      logic exec;    // run the captured command on its timer
      logic scan;    // tick one timer at the scan index
      logic flush;   // send the held expiry as the last result
   } dp_cmd_type;

endpackage

// File: design/ostb_ctrl.sv
// ostb_ctrl: sequencer for the timer bank. Accepts requests, runs the tick
// scan over all timer slots and steps the datapath. Depends on ostb_pkg.
module ostb_ctrl #(
   parameter int NUM_SLOTS = 8,
   parameter int SLOT_W    = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2:0]          op,
   output logic                busy,
   output ostb_pkg::dp_cmd_type cmd,
   output logic [SLOT_W-1:0]   scan_idx
);
   import ostb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              busy_ff;
   logic              accept;

   assign accept = start && !busy_ff;

   // Next state and scan index
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (op == OP_TICK) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, index and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy      = busy_ff;
   assign scan_idx  = idx_ff;
   assign cmd.load  = accept;
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign cmd.scan  = (state_ff == ST_SCAN);
   assign cmd.flush = (state_ff == ST_FLUSH);

endmodule

// File: design/ostb_dpath.sv
// ostb_dpath: timer state (flags, counts, periods), command execution,
// tick update and result registers. Depends on ostb_pkg.
module ostb_dpath #(
   parameter int NUM_SLOTS = 8,
   parameter int SLOT_W    = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  ostb_pkg::dp_cmd_type cmd,
   input  logic [SLOT_W-1:0]   scan_idx,
   input  logic [2:0]          req_op,
   input  logic [2:0]          req_timer_id,
   input  logic [15:0]         req_period_ticks,
   input  logic                req_run,
   input  logic                req_handler_present,
   output logic                rsp_strobe,
   output logic                rsp_kind,
   output logic [2:0]          rsp_event_timer,
   output logic                rsp_success,
   output logic                rsp_last
);
   import ostb_pkg::*;

   // Captured request
   logic [2:0]  op_ff;
   logic [2:0]  tid_ff;
   logic [15:0] per_ff;
   logic        run_ff;
   logic        hnd_ff;

   // Timer state
   logic [NUM_SLOTS-1:0] exists_ff, exists_in;
   logic [NUM_SLOTS-1:0] runf_ff, runf_in;
   logic [15:0]          cnt_ff [NUM_SLOTS];
   logic [15:0]          cnt_in [NUM_SLOTS];
   logic [15:0]          prd_ff [NUM_SLOTS];
   logic [15:0]          prd_in [NUM_SLOTS];

   // Held expiry, sent once the next one or the scan end is known
   logic       pend_vld_ff, pend_vld_in;
   logic [2:0] pend_id_ff, pend_id_in;

   // Result registers
   logic       rsp_vld_ff, rsp_vld_in;
   logic       kind_ff, kind_in;
   logic [2:0] tmr_ff, tmr_in;
   logic       ok_ff, ok_in;
   logic       last_ff, last_in;

   // Shared access index: scan slot or command slot
   logic              in_range;
   logic [SLOT_W-1:0] acc_idx;
   logic              sel_ex;
   logic              sel_rn;
   logic [15:0]       sel_cnt;
   logic [15:0]       sel_prd;
   logic [15:0]       cnt_inc;
   logic              expire;

   assign in_range = (32'(tid_ff) < NUM_SLOTS);
   assign acc_idx  = cmd.scan ? scan_idx :
                     (in_range ? tid_ff[SLOT_W-1:0] : '0);
   assign sel_ex   = exists_ff[acc_idx];
   assign sel_rn   = runf_ff[acc_idx];
   assign sel_cnt  = cnt_ff[acc_idx];
   assign sel_prd  = prd_ff[acc_idx];
   assign cnt_inc  = (sel_cnt != COUNT_MAX) ? sel_cnt + 16'd1 : sel_cnt;
   assign expire   = sel_ex && sel_rn && (cnt_inc >= sel_prd);

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         tid_ff <= req_timer_id;
         per_ff <= req_period_ticks;
         run_ff <= req_run;
         hnd_ff <= req_handler_present;
      end
   end

   // Next timer state and results
   always_comb begin
      exists_in   = exists_ff;
      runf_in     = runf_ff;
      cnt_in      = cnt_ff;
      prd_in      = prd_ff;
      pend_vld_in = pend_vld_ff;
      pend_id_in  = pend_id_ff;
      rsp_vld_in  = 1'b0;
      kind_in     = kind_ff;
      tmr_in      = tmr_ff;
      ok_in       = ok_ff;
      last_in     = last_ff;

      if (cmd.scan) begin
         // Tick one timer
         if (sel_ex && sel_rn) begin
            cnt_in[acc_idx] = cnt_inc;
         end
         if (expire) begin
            runf_in[acc_idx] = 1'b0;
            if (pend_vld_ff) begin
               rsp_vld_in = 1'b1;
               kind_in    = KIND_EXPIRY;
               tmr_in     = pend_id_ff;
               ok_in      = 1'b1;
               last_in    = 1'b0;
            end
            pend_vld_in = 1'b1;
            pend_id_in  = 3'(acc_idx);
         end
      end else if (cmd.flush) begin
         // Last expiry of this tick, if any
         rsp_vld_in  = pend_vld_ff;
         kind_in     = KIND_EXPIRY;
         tmr_in      = pend_id_ff;
         ok_in       = 1'b1;
         last_in     = 1'b1;
         pend_vld_in = 1'b0;
      end else if (cmd.exec) begin
         // Single-timer command with status
         rsp_vld_in = 1'b1;
         kind_in    = KIND_STATUS;
         tmr_in     = tid_ff;
         last_in    = 1'b1;
         ok_in      = 1'b0;
         case (op_ff)
            OP_CREATE: begin
               if (in_range) begin
                  exists_in[acc_idx] = hnd_ff;
                  runf_in[acc_idx]   = run_ff;
                  cnt_in[acc_idx]    = '0;
                  prd_in[acc_idx]    = per_ff;
                  ok_in              = 1'b1;
               end
            end
            OP_CONTROL: begin
               if (in_range && sel_ex) begin
                  runf_in[acc_idx] = run_ff;
                  ok_in            = 1'b1;
               end
            end
            OP_DELETE: begin
               if (in_range && sel_ex) begin
                  exists_in[acc_idx] = 1'b0;
                  runf_in[acc_idx]   = 1'b0;
                  cnt_in[acc_idx]    = '0;
                  ok_in              = 1'b1;
               end
            end
            OP_RESET: begin
               if (in_range && sel_ex) begin
                  runf_in[acc_idx] = run_ff;
                  cnt_in[acc_idx]  = '0;
                  ok_in            = 1'b1;
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   // Flags and strobes; counts and periods are only read after a create
   always_ff @(posedge clock) begin
      if (reset) begin
         exists_ff   <= '0;
         runf_ff     <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         exists_ff   <= exists_in;
         runf_ff     <= runf_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      prd_ff     <= prd_in;
      pend_id_ff <= pend_id_in;
      kind_ff    <= kind_in;
      tmr_ff     <= tmr_in;
      ok_ff      <= ok_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe      = rsp_vld_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_event_timer = tmr_ff;
   assign rsp_success     = ok_ff;
   assign rsp_last        = last_ff;

endmodule

// File: design/one_shot_soft_timer_bank.sv
// one_shot_soft_timer_bank: bank of one-shot software timers.
// Usage:
//   Requests: drive req_* and raise start; a request transfers at a rising
//   edge where start is high and busy is low.
//   Results: each result shows on rsp_* for one cycle with rsp_strobe high
//   and transfers at the end of that cycle; the receiver cannot stall them.
//   Commands (create, control, delete, reset, unknown op) give one status
//   result, strobed after the command runs in the exec state and the result
//   is registered; busy is high for one cycle while it runs, so no new
//   request is taken before then. A tick scans the timer slots one per
//   cycle, min(NUM_TIMERS, 8) of them, then sends the final expiry in a
//   flush step; busy stays high throughout, so no request is taken meanwhile.
//   Expiries come out in timer order, one per cycle at most. Each one is held
//   until the next expiring slot is scanned or the flush step after the scan,
//   and is then registered onto rsp_*; rsp_last marks the final one.
//   A tick that expires nothing gives no result.
//   Timers above index 7 cannot be addressed and hold no state.
//   Reset: synchronous, clears all exists and run flags and any pending
//   result; the block is ready in the cycle after reset.
// Depends on ostb_pkg, ostb_ctrl, ostb_dpath.
module one_shot_soft_timer_bank #(
   parameter int NUM_TIMERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [2:0]  req_timer_id,
   input  logic [15:0] req_period_ticks,
   input  logic        req_run,
   input  logic        req_handler_present,
   output logic        rsp_strobe,
   output logic        rsp_kind,
   output logic [2:0]  rsp_event_timer,
   output logic        rsp_success,
   output logic        rsp_last
);
   import ostb_pkg::*;

   localparam int NUM_SLOTS = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   dp_cmd_type        cmd;
   logic [SLOT_W-1:0] scan_idx;

   ostb_ctrl #(
      .NUM_SLOTS (NUM_SLOTS),
      .SLOT_W    (SLOT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req_op),
      .busy     (busy),
      .cmd      (cmd),
      .scan_idx (scan_idx)
   );

   ostb_dpath #(
      .NUM_SLOTS (NUM_SLOTS),
      .SLOT_W    (SLOT_W)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .scan_idx            (scan_idx),
      .req_op              (req_op),
      .req_timer_id        (req_timer_id),
      .req_period_ticks    (req_period_ticks),
      .req_run             (req_run),
      .req_handler_present (req_handler_present),
      .rsp_strobe          (rsp_strobe),
      .rsp_kind            (rsp_kind),
      .rsp_event_timer     (rsp_event_timer),
      .rsp_success         (rsp_success),
      .rsp_last            (rsp_last)
   );

endmodule
